### design/vfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfa_pkg
// Types, codes and arithmetic helpers for the Q16.16 three-component vector
// arithmetic unit.
// ----------------------------------------------------------------------------
package vfa_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_BITS  = 2 * WORD_BITS;
   localparam int ACC_BITS   = PROD_BITS + 2;
   localparam int ROOT_STEPS = WORD_BITS;
   localparam int REM_BITS   = WORD_BITS + 3;
   localparam int QUOT_BITS  = FRAC_BITS + 1;
   localparam int NUM_BITS   = WORD_BITS + FRAC_BITS;
   localparam int MUL_LANES  = 6;

   typedef enum logic [3:0] {
      FN_ADD       = 4'd0,
      FN_SUB       = 4'd1,
      FN_NEGATE    = 4'd2,
      FN_SCALE     = 4'd3,
      FN_DOT       = 4'd4,
      FN_CROSS     = 4'd5,
      FN_MAGNITUDE = 4'd6,
      FN_NORMALIZE = 4'd7,
      FN_SELECT    = 4'd8
   } func_type;

   localparam logic [1:0] IDX_X    = 2'd0;
   localparam logic [1:0] IDX_Y    = 2'd1;
   localparam logic [1:0] IDX_Z    = 2'd2;
   localparam logic [1:0] IDX_NONE = 2'd3;

   typedef logic [WORD_BITS-1:0]        word_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [ACC_BITS-1:0]  acc_type;

   typedef struct packed {
      logic               ovf;
      word_type           val;
   } sat_type;

   // Control and result fields that ride along every stage.
   typedef struct packed {
      logic               valid;
      func_type           func;
      word_type [2:0]     a;
      word_type [2:0]     r;
      word_type           sc;
      logic               ovf;
      logic               zl;
   } ctl_type;

   typedef struct packed {
      ctl_type                  ctl;
      word_type [MUL_LANES-1:0] ma;
      word_type [MUL_LANES-1:0] mb;
   } opnd_type;

   typedef struct packed {
      ctl_type                  ctl;
      prod_type [MUL_LANES-1:0] p;
   } prod_stage_type;

   typedef struct packed {
      ctl_type                ctl;
      logic [PROD_BITS-1:0]   rad;
      logic [REM_BITS-1:0]    rem;
      word_type               root;
   } srt_type;

   typedef struct packed {
      ctl_type                     ctl;
      word_type                    m;
      logic [2:0][NUM_BITS-1:0]    drem;
      logic [2:0][QUOT_BITS-1:0]   q;
   } div_type;

   function automatic acc_type ext_acc(input word_type v);
      return {{(ACC_BITS-WORD_BITS){v[WORD_BITS-1]}}, v};
   endfunction

   function automatic prod_type ext_prod(input word_type v);
      return {{(PROD_BITS-WORD_BITS){v[WORD_BITS-1]}}, v};
   endfunction

   function automatic acc_type ext_wide(input prod_type v);
      return {{(ACC_BITS-PROD_BITS){v[PROD_BITS-1]}}, v};
   endfunction

   // Clamp a wide signed value to the word range and report clamping.
   function automatic sat_type sat_word(input acc_type v);
      sat_type s;
      s.ovf = 1'b0;
      s.val = v[WORD_BITS-1:0];
      if (!v[ACC_BITS-1] && (|v[ACC_BITS-2:WORD_BITS-1])) begin
         s.ovf = 1'b1;
         s.val = {1'b0, {(WORD_BITS-1){1'b1}}};
      end else if (v[ACC_BITS-1] && !(&v[ACC_BITS-2:WORD_BITS-1])) begin
         s.ovf = 1'b1;
         s.val = {1'b1, {(WORD_BITS-1){1'b0}}};
      end
      return s;
   endfunction

   // One step of the integer square root: two radicand bits in, one root bit out.
   function automatic srt_type sqrt_step(input srt_type s);
      srt_type             o;
      logic [REM_BITS-1:0] cur;
      logic [REM_BITS-1:0] trial;
      o     = s;
      cur   = {s.rem[REM_BITS-3:0], s.rad[PROD_BITS-1 -: 2]};
      trial = REM_BITS'({s.root, 2'b01});
      o.rad = {s.rad[PROD_BITS-3:0], 2'b00};
      if (cur >= trial) begin
         o.rem  = cur - trial;
         o.root = {s.root[WORD_BITS-2:0], 1'b1};
      end else begin
         o.rem  = cur;
         o.root = {s.root[WORD_BITS-2:0], 1'b0};
      end
      return o;
   endfunction

   // Loads the divider: numerators are |a| scaled by one, divisor the root.
   function automatic div_type div_init(input srt_type s);
      div_type  o;
      word_type mag;
      o.ctl = s.ctl;
      o.m   = s.root;
      o.q   = '0;
      for (int i = 0; i < 3; i++) begin
         mag       = s.ctl.a[i][WORD_BITS-1] ? (~s.ctl.a[i] + 1'b1) : s.ctl.a[i];
         o.drem[i] = {mag, {FRAC_BITS{1'b0}}};
      end
      return o;
   endfunction

   // One restoring quotient bit, at weight 2^k, for all three lanes.
   function automatic div_type div_step(input div_type s, input int k);
      div_type             o;
      logic [NUM_BITS:0]   dsor;
      o    = s;
      dsor = (NUM_BITS + 1)'(s.m) << k;
      for (int i = 0; i < 3; i++) begin
         if ({1'b0, s.drem[i]} >= dsor) begin
            o.drem[i] = s.drem[i] - dsor[NUM_BITS-1:0];
            o.q[i]    = {s.q[i][QUOT_BITS-2:0], 1'b1};
         end else begin
            o.q[i]    = {s.q[i][QUOT_BITS-2:0], 1'b0};
         end
      end
      return o;
   endfunction

endpackage

### design/vector3_fixed_point_alu_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_unit
// Pipelined signed Q16.16 vector unit: add, subtract, negate, scale, dot,
// cross, magnitude, normalize and component select.
// ----------------------------------------------------------------------------
// The unit takes one request beat per clock and returns one response beat per
// request, in order. Every operation travels the same pipeline: an operand
// register, a bank of six 32x32 multipliers, a sum and saturate stage, a
// 32-stage square root that retires one root bit per stage, a 17-stage
// restoring divider that retires one quotient bit per stage for all three
// components at once, and the response register. Throughput is one beat per
// cycle while rsp_ready keeps the pipeline moving. When a response
// beat waits on rsp_ready the whole pipeline holds, so req_ready is low only
// while the response register is full and not being taken. Results saturate
// to the Q16.16 range and raise overflow; normalizing a zero vector returns a
// zero vector with zero_length set. Unknown function codes return all zeros.
module vector3_fixed_point_alu_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [3:0]                         req_func,
   input  logic signed [vfa_pkg::WORD_BITS-1:0] req_a_x,
   input  logic signed [vfa_pkg::WORD_BITS-1:0] req_a_y,
   input  logic signed [vfa_pkg::WORD_BITS-1:0] req_a_z,
   input  logic signed [vfa_pkg::WORD_BITS-1:0] req_b_x,
   input  logic signed [vfa_pkg::WORD_BITS-1:0] req_b_y,
   input  logic signed [vfa_pkg::WORD_BITS-1:0] req_b_z,
   input  logic signed [vfa_pkg::WORD_BITS-1:0] req_scale_factor,
   input  logic [1:0]                         req_component_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [vfa_pkg::WORD_BITS-1:0] rsp_res_x,
   output logic signed [vfa_pkg::WORD_BITS-1:0] rsp_res_y,
   output logic signed [vfa_pkg::WORD_BITS-1:0] rsp_res_z,
   output logic signed [vfa_pkg::WORD_BITS-1:0] rsp_res_scalar,
   output logic                               rsp_overflow,
   output logic                               rsp_zero_length
);
   import vfa_pkg::*;

   // All stages move together; a full, untaken response freezes them.
   logic           adv;

   opnd_type       op_ff, op_in;
   prod_stage_type mul_ff, mul_in;
   srt_type        sum_ff, sum_in;
   srt_type        sq_ff [ROOT_STEPS];
   srt_type        sq_in [ROOT_STEPS];
   div_type        dv_ff [QUOT_BITS];
   div_type        dv_in [QUOT_BITS];
   ctl_type        out_ff, out_in;

   assign adv       = !out_ff.valid || rsp_ready;
   assign req_ready = adv;

   // Operand stage: the add-class and select results are finished here, and
   // the multiplier operands are steered for the product-based operations.
   always_comb begin
      word_type [2:0] ra;
      word_type [2:0] rb;
      sat_type        t;
      ra = {req_a_z, req_a_y, req_a_x};
      rb = {req_b_z, req_b_y, req_b_x};
      t  = '0;
      op_in           = '0;
      op_in.ctl.valid = req_valid;
      op_in.ctl.func  = func_type'(req_func);
      op_in.ctl.a     = ra;
      unique case (func_type'(req_func))
         FN_ADD: begin
            for (int i = 0; i < 3; i++) begin
               t = sat_word(ext_acc(ra[i]) + ext_acc(rb[i]));
               op_in.ctl.r[i] = t.val;
               op_in.ctl.ovf  = op_in.ctl.ovf | t.ovf;
            end
         end
         FN_SUB: begin
            for (int i = 0; i < 3; i++) begin
               t = sat_word(ext_acc(ra[i]) - ext_acc(rb[i]));
               op_in.ctl.r[i] = t.val;
               op_in.ctl.ovf  = op_in.ctl.ovf | t.ovf;
            end
         end
         FN_NEGATE: begin
            for (int i = 0; i < 3; i++) begin
               t = sat_word(-ext_acc(ra[i]));
               op_in.ctl.r[i] = t.val;
               op_in.ctl.ovf  = op_in.ctl.ovf | t.ovf;
            end
         end
         FN_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               op_in.ma[i] = req_scale_factor;
               op_in.mb[i] = ra[i];
            end
         end
         FN_DOT: begin
            for (int i = 0; i < 3; i++) begin
               op_in.ma[i] = ra[i];
               op_in.mb[i] = rb[i];
            end
         end
         FN_CROSS: begin
            op_in.ma[0] = ra[1]; op_in.mb[0] = rb[2];
            op_in.ma[1] = ra[2]; op_in.mb[1] = rb[1];
            op_in.ma[2] = ra[2]; op_in.mb[2] = rb[0];
            op_in.ma[3] = ra[0]; op_in.mb[3] = rb[2];
            op_in.ma[4] = ra[0]; op_in.mb[4] = rb[1];
            op_in.ma[5] = ra[1]; op_in.mb[5] = rb[0];
         end
         FN_MAGNITUDE, FN_NORMALIZE: begin
            for (int i = 0; i < 3; i++) begin
               op_in.ma[i] = ra[i];
               op_in.mb[i] = ra[i];
            end
         end
         FN_SELECT: begin
            unique case (req_component_index)
               IDX_X:    op_in.ctl.sc = ra[0];
               IDX_Y:    op_in.ctl.sc = ra[1];
               IDX_Z:    op_in.ctl.sc = ra[2];
               IDX_NONE: op_in.ctl.sc = '0;
            endcase
         end
         default: begin
            op_in.ctl.sc = '0;
         end
      endcase
   end

   // Multiplier stage.
   always_comb begin
      mul_in.ctl = op_ff.ctl;
      for (int i = 0; i < MUL_LANES; i++) begin
         mul_in.p[i] = ext_prod(op_ff.ma[i]) * ext_prod(op_ff.mb[i]);
      end
   end

   // Sum stage: exact sums, floor shift, saturation; loads the root chain.
   always_comb begin
      acc_type              acc;
      sat_type              t;
      logic [PROD_BITS-1:0] ss;
      acc = '0;
      t   = '0;
      ss  = mul_ff.p[0] + mul_ff.p[1] + mul_ff.p[2];
      sum_in      = '0;
      sum_in.ctl  = mul_ff.ctl;
      unique case (mul_ff.ctl.func)
         FN_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               t = sat_word(ext_wide(mul_ff.p[i]) >>> FRAC_BITS);
               sum_in.ctl.r[i] = t.val;
               sum_in.ctl.ovf  = sum_in.ctl.ovf | t.ovf;
            end
         end
         FN_DOT: begin
            acc = ext_wide(mul_ff.p[0]) + ext_wide(mul_ff.p[1]) + ext_wide(mul_ff.p[2]);
            t   = sat_word(acc >>> FRAC_BITS);
            sum_in.ctl.sc  = t.val;
            sum_in.ctl.ovf = t.ovf;
         end
         FN_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               acc = ext_wide(mul_ff.p[2*i]) - ext_wide(mul_ff.p[2*i+1]);
               t   = sat_word(acc >>> FRAC_BITS);
               sum_in.ctl.r[i] = t.val;
               sum_in.ctl.ovf  = sum_in.ctl.ovf | t.ovf;
            end
         end
         FN_MAGNITUDE: begin
            sum_in.rad = ss;
         end
         FN_NORMALIZE: begin
            sum_in.rad    = ss;
            sum_in.ctl.zl = (ss == '0);
         end
         default: begin
            sum_in.rad = '0;
         end
      endcase
   end

   // Square root chain, one root bit per stage.
   always_comb begin
      sq_in[0] = sqrt_step(sum_ff);
      for (int k = 1; k < ROOT_STEPS; k++) begin
         sq_in[k] = sqrt_step(sq_ff[k-1]);
      end
   end

   // Divider chain, one quotient bit per stage, most significant first.
   always_comb begin
      dv_in[0] = div_step(div_init(sq_ff[ROOT_STEPS-1]), QUOT_BITS - 1);
      for (int j = 1; j < QUOT_BITS; j++) begin
         dv_in[j] = div_step(dv_ff[j-1], QUOT_BITS - 1 - j);
      end
   end

   // Response stage: magnitude clamp and normalize sign restore.
   always_comb begin
      div_type last;
      last   = dv_ff[QUOT_BITS-1];
      out_in = last.ctl;
      if (last.ctl.func == FN_MAGNITUDE) begin
         if (last.m[WORD_BITS-1]) begin
            out_in.sc  = {1'b0, {(WORD_BITS-1){1'b1}}};
            out_in.ovf = 1'b1;
         end else begin
            out_in.sc = last.m;
         end
      end else if (last.ctl.func == FN_NORMALIZE && !last.ctl.zl) begin
         for (int i = 0; i < 3; i++) begin
            out_in.r[i] = last.ctl.a[i][WORD_BITS-1]
                        ? ~WORD_BITS'(last.q[i]) + 1'b1
                        : WORD_BITS'(last.q[i]);
         end
      end
   end

   // Reset clears only the valid bits; the data fields need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff.ctl.valid  <= 1'b0;
         mul_ff.ctl.valid <= 1'b0;
         sum_ff.ctl.valid <= 1'b0;
         for (int k = 0; k < ROOT_STEPS; k++) begin
            sq_ff[k].ctl.valid <= 1'b0;
         end
         for (int j = 0; j < QUOT_BITS; j++) begin
            dv_ff[j].ctl.valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         op_ff  <= op_in;
         mul_ff <= mul_in;
         sum_ff <= sum_in;
         sq_ff  <= sq_in;
         dv_ff  <= dv_in;
         out_ff <= out_in;
      end
   end

   assign rsp_valid       = out_ff.valid;
   assign rsp_res_x       = out_ff.r[0];
   assign rsp_res_y       = out_ff.r[1];
   assign rsp_res_z       = out_ff.r[2];
   assign rsp_res_scalar  = out_ff.sc;
   assign rsp_overflow    = out_ff.ovf;
   assign rsp_zero_length = out_ff.zl;

`ifndef SYNTHESIS
   // An accepted request beat lands in the operand stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> op_ff.ctl.valid)
      else $error("accepted request beat not captured");

   // The root remainder never exceeds twice the partial root.
   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      sq_ff[ROOT_STEPS-1].ctl.valid |->
         (sq_ff[ROOT_STEPS-1].rem <= REM_BITS'({sq_ff[ROOT_STEPS-1].root, 1'b0})))
      else $error("square root remainder out of bound");

   // A normalized component never exceeds one.
   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (dv_ff[QUOT_BITS-1].ctl.valid && dv_ff[QUOT_BITS-1].ctl.func == FN_NORMALIZE
         && !dv_ff[QUOT_BITS-1].ctl.zl) |->
         (dv_ff[QUOT_BITS-1].q[0] <= QUOT_BITS'(1 << FRAC_BITS)
          && dv_ff[QUOT_BITS-1].q[1] <= QUOT_BITS'(1 << FRAC_BITS)
          && dv_ff[QUOT_BITS-1].q[2] <= QUOT_BITS'(1 << FRAC_BITS)))
      else $error("normalize quotient above one");

   // A zero-length response carries a zero vector and no overflow.
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_length) |->
         (rsp_res_x == '0 && rsp_res_y == '0 && rsp_res_z == '0 && !rsp_overflow))
      else $error("zero-length response with nonzero payload");
`endif

endmodule

### dv/tb_vector3_fixed_point_alu_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector3_fixed_point_alu_unit
// Self-checking bench for the Q16.16 three-component vector unit.
// ----------------------------------------------------------------------------
// A short table of directed beats (saturation limits, every function code,
// zero-length normalize, select of index three, undefined codes) is followed
// by about four hundred random beats. Each accepted request beat queues its
// expected result (table or bit-exact model) and each accepted response beat
// is compared field by field with the oldest queued result. Both sides insert
// random gaps so that stalls land on every stage of the pipeline.
// ----------------------------------------------------------------------------
module tb_vector3_fixed_point_alu_unit;
   import vfa_pkg::*;

   // Function codes above FN_SELECT are undefined and must return zeros.
   localparam logic [3:0] FN_UNDEF_FIRST = 4'd9;
   localparam logic [3:0] FN_UNDEF_LAST  = 4'd15;
   localparam logic [31:0] Q_MAX  = 32'h7fff_ffff;
   localparam logic [31:0] Q_MIN  = 32'h8000_0000;
   localparam logic [31:0] Q_ONE  = 32'h0001_0000;
   localparam int RANDOM_BEATS    = 400;
   localparam int PIPE_LATENCY    = 53;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [31:0] x, y, z, sc;
      logic        ovf, zl;
   } vec_result_type;

   typedef struct {
      logic [3:0]     func;
      logic [31:0]    a [3];
      logic [31:0]    b [3];
      logic [31:0]    s;
      logic [1:0]     idx;
      bit             typed;
      vec_result_type want;
   } beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_func = '0;
   logic signed [31:0] req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic signed [31:0] req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic signed [31:0] req_scale_factor = '0;
   logic [1:0] req_component_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_res_x, rsp_res_y, rsp_res_z, rsp_res_scalar;
   logic rsp_overflow, rsp_zero_length;

   vector3_fixed_point_alu_unit u_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Arithmetic model
   // -------------------------------------------------------------------------
   // Clamp a wide exact value to Q16.16 and note any clamping.
   function automatic logic [31:0] clamp_q(input wide_type v, inout logic ovf);
      if (v > wide_type'(signed'(Q_MAX))) begin
         ovf = 1'b1;
         return Q_MAX;
      end
      if (v < wide_type'(signed'(Q_MIN))) begin
         ovf = 1'b1;
         return Q_MIN;
      end
      return v[31:0];
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned r, b4;
      r  = 0;
      b4 = 64'd1 << 62;
      while (b4 > n) b4 >>= 2;
      while (b4 != 0) begin
         if (n >= r + b4) begin
            n -= r + b4;
            r = (r >> 1) + b4;
         end else begin
            r >>= 1;
         end
         b4 >>= 2;
      end
      return r;
   endfunction

   function automatic vec_result_type vector_result(input beat_type t);
      vec_result_type  o;
      wide_type        a [3], b [3], s, acc;
      longint unsigned sq, m, mag;
      logic [31:0]     q;
      o = '{default: '0};
      for (int i = 0; i < 3; i++) begin
         a[i] = wide_type'(signed'(t.a[i]));
         b[i] = wide_type'(signed'(t.b[i]));
      end
      s  = wide_type'(signed'(t.s));
      sq = longint'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      case (t.func)
         FN_ADD: begin
            o.x = clamp_q(a[0] + b[0], o.ovf);
            o.y = clamp_q(a[1] + b[1], o.ovf);
            o.z = clamp_q(a[2] + b[2], o.ovf);
         end
         FN_SUB: begin
            o.x = clamp_q(a[0] - b[0], o.ovf);
            o.y = clamp_q(a[1] - b[1], o.ovf);
            o.z = clamp_q(a[2] - b[2], o.ovf);
         end
         FN_NEGATE: begin
            o.x = clamp_q(-a[0], o.ovf);
            o.y = clamp_q(-a[1], o.ovf);
            o.z = clamp_q(-a[2], o.ovf);
         end
         FN_SCALE: begin
            o.x = clamp_q((s * a[0]) >>> FRAC_BITS, o.ovf);
            o.y = clamp_q((s * a[1]) >>> FRAC_BITS, o.ovf);
            o.z = clamp_q((s * a[2]) >>> FRAC_BITS, o.ovf);
         end
         FN_DOT: begin
            acc  = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
            o.sc = clamp_q(acc >>> FRAC_BITS, o.ovf);
         end
         FN_CROSS: begin
            o.x = clamp_q((a[1] * b[2] - a[2] * b[1]) >>> FRAC_BITS, o.ovf);
            o.y = clamp_q((a[2] * b[0] - a[0] * b[2]) >>> FRAC_BITS, o.ovf);
            o.z = clamp_q((a[0] * b[1] - a[1] * b[0]) >>> FRAC_BITS, o.ovf);
         end
         FN_MAGNITUDE: begin
            o.sc = clamp_q(wide_type'(root_floor(sq)), o.ovf);
         end
         FN_NORMALIZE: begin
            // A zero vector has no direction; flag it and return zeros.
            if (sq == 0) begin
               o.zl = 1'b1;
            end else begin
               m = root_floor(sq);
               for (int i = 0; i < 3; i++) begin
                  mag = longint'(a[i] < 0 ? -a[i] : a[i]);
                  acc = wide_type'((mag << FRAC_BITS) / m);
                  q   = clamp_q(a[i] < 0 ? -acc : acc, o.ovf);
                  if (i == 0) o.x = q;
                  else if (i == 1) o.y = q;
                  else o.z = q;
               end
            end
         end
         FN_SELECT: begin
            o.sc = (t.idx == IDX_NONE) ? '0 : t.a[t.idx];
         end
         default: ;
      endcase
      return o;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic beat_type mk(input logic [3:0] f,
                                   input logic [31:0] ax, ay, az, bx, by, bz, s,
                                   input logic [1:0] idx);
      beat_type t;
      t.func  = f;
      t.a     = '{ax, ay, az};
      t.b     = '{bx, by, bz};
      t.s     = s;
      t.idx   = idx;
      t.typed = 1'b0;
      t.want  = '{default: '0};
      return t;
   endfunction

   function automatic beat_type with_result(input beat_type t, input logic [31:0] x, y, z,
                                            sc, input logic ovf, zl);
      t.typed = 1'b1;
      t.want  = '{x: x, y: y, z: z, sc: sc, ovf: ovf, zl: zl};
      return t;
   endfunction

   // Mix of limits, zero, small values near the unit range and raw words.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return '0;
         3, 4: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
         5: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic beat_type random_beat();
      beat_type t;
      logic [3:0] f;
      f = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(FN_UNDEF_FIRST, FN_UNDEF_LAST))
                                       : 4'($urandom_range(FN_ADD, FN_SELECT));
      t = mk(f, pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
             pick_word(), pick_word(), 2'($urandom_range(0, 3)));
      // Zero vectors are rare from the mix above, so plant some for normalize.
      if (f == FN_NORMALIZE && $urandom_range(0, 5) == 0) t.a = '{'0, '0, '0};
      return t;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 2) != 0) return 0;
      if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // -------------------------------------------------------------------------
   // Scoreboard
   // -------------------------------------------------------------------------
   vec_result_type pending_results [$];
   vec_result_type drive_result;
   int             mismatch_count = 0;
   int             beats_checked  = 0;
   int             beats_sent     = 0;

   always @(posedge clock) begin
      vec_result_type w;
      if (!reset && req_valid && req_ready) begin
         pending_results.push_back(drive_result);
         beats_sent++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("ERROR: response beat with none pending");
         end else begin
            w = pending_results.pop_front();
            beats_checked++;
            if (w.x !== rsp_res_x || w.y !== rsp_res_y || w.z !== rsp_res_z ||
                w.sc !== rsp_res_scalar || w.ovf !== rsp_overflow ||
                w.zl !== rsp_zero_length) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("ERROR: beat %0d exp x=%h y=%h z=%h sc=%h ovf=%b zl=%b",
                           beats_checked, w.x, w.y, w.z, w.sc, w.ovf, w.zl);
                  $display("       got x=%h y=%h z=%h sc=%h ovf=%b zl=%b",
                           rsp_res_x, rsp_res_y, rsp_res_z, rsp_res_scalar,
                           rsp_overflow, rsp_zero_length);
               end
            end
         end
      end
   end

   // Response side backpressure: runs of ready and stalls of random length.
   initial begin
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(0, 3) != 0);
         repeat (gap_len()) @(negedge clock);
      end
   end

   // Drive one request beat and hold it until the unit takes it.
   task automatic send_beat(input beat_type t);
      int gap;
      @(negedge clock);
      drive_result        = t.typed ? t.want : vector_result(t);
      req_valid           <= 1'b1;
      req_func            <= t.func;
      req_a_x             <= t.a[0];
      req_a_y             <= t.a[1];
      req_a_z             <= t.a[2];
      req_b_x             <= t.b[0];
      req_b_y             <= t.b[1];
      req_b_z             <= t.b[2];
      req_scale_factor    <= t.s;
      req_component_index <= t.idx;
      do @(posedge clock); while (!req_ready);
      gap = gap_len();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   beat_type directed [$];

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Plain sums and the saturation limits of add, subtract and negate.
      directed.push_back(with_result(mk(FN_ADD, Q_ONE, Q_ONE, '0, 32'h2_0000, Q_MIN, '0,
                         '0, IDX_X), 32'h3_0000, 32'h8001_0000, '0, '0, 1'b0, 1'b0));
      directed.push_back(with_result(mk(FN_ADD, Q_MAX, Q_MAX, Q_MAX, 32'd1, 32'd1, 32'd1,
                         '0, IDX_X), Q_MAX, Q_MAX, Q_MAX, '0, 1'b1, 1'b0));
      directed.push_back(with_result(mk(FN_SUB, Q_MIN, Q_MIN, Q_MIN, 32'd1, 32'd1, 32'd1,
                         '0, IDX_X), Q_MIN, Q_MIN, Q_MIN, '0, 1'b1, 1'b0));
      directed.push_back(with_result(mk(FN_NEGATE, Q_MIN, Q_MAX, '0, '0, '0, '0, '0,
                         IDX_X), Q_MAX, 32'h8000_0001, '0, '0, 1'b1, 1'b0));
      directed.push_back(mk(FN_SCALE, Q_MAX, Q_MIN, 32'hffff_0000, '0, '0, '0, Q_MIN, IDX_Y));
      directed.push_back(mk(FN_SCALE, 32'h1_8000, 32'hffff_ffff, Q_ONE, '0, '0, '0,
                            32'h0000_8000, IDX_Z));
      directed.push_back(mk(FN_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, '0, IDX_X));
      directed.push_back(mk(FN_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, '0, IDX_X));
      directed.push_back(mk(FN_DOT, 32'hffff_ffff, 32'd1, '0, 32'd1, 32'd1, '0, '0, IDX_X));
      directed.push_back(mk(FN_CROSS, Q_ONE, '0, '0, '0, Q_ONE, '0, '0, IDX_X));
      directed.push_back(mk(FN_CROSS, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, '0, IDX_X));
      directed.push_back(with_result(mk(FN_MAGNITUDE, 32'h3_0000, 32'h4_0000, '0, '0, '0,
                         '0, '0, IDX_X), '0, '0, '0, 32'h5_0000, 1'b0, 1'b0));
      directed.push_back(mk(FN_MAGNITUDE, Q_MIN, Q_MIN, Q_MIN, '0, '0, '0, '0, IDX_X));
      directed.push_back(with_result(mk(FN_NORMALIZE, '0, '0, '0, Q_MAX, Q_MAX, Q_MAX,
                         Q_MAX, IDX_X), '0, '0, '0, '0, 1'b0, 1'b1));
      directed.push_back(mk(FN_NORMALIZE, 32'h3_0000, 32'hfffc_0000, '0, '0, '0, '0, '0,
                            IDX_X));
      directed.push_back(mk(FN_NORMALIZE, 32'd1, '0, '0, '0, '0, '0, '0, IDX_X));
      directed.push_back(mk(FN_NORMALIZE, Q_MIN, Q_MAX, 32'd7, '0, '0, '0, '0, IDX_X));
      directed.push_back(with_result(mk(FN_SELECT, 32'd5, 32'd6, 32'd7, '0, '0, '0, '0,
                         IDX_X), '0, '0, '0, 32'd5, 1'b0, 1'b0));
      directed.push_back(mk(FN_SELECT, 32'd5, Q_MIN, 32'd7, '0, '0, '0, '0, IDX_Y));
      directed.push_back(mk(FN_SELECT, 32'd5, 32'd6, Q_MAX, '0, '0, '0, '0, IDX_Z));
      directed.push_back(with_result(mk(FN_SELECT, Q_MAX, Q_MAX, Q_MAX, '0, '0, '0, '0,
                         IDX_NONE), '0, '0, '0, '0, 1'b0, 1'b0));
      directed.push_back(with_result(mk(FN_UNDEF_FIRST, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                         Q_MAX, Q_MAX, IDX_NONE), '0, '0, '0, '0, 1'b0, 1'b0));
      directed.push_back(with_result(mk(FN_UNDEF_LAST, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                         Q_MIN, Q_MIN, IDX_NONE), '0, '0, '0, '0, 1'b0, 1'b0));

      foreach (directed[i]) send_beat(directed[i]);
      repeat (RANDOM_BEATS) send_beat(random_beat());

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (PIPE_LATENCY + 10) @(posedge clock);

      $display("Sent %0d request beats (%0d directed), checked %0d response beats,",
               beats_sent, directed.size(), beats_checked);
      $display("%0d mismatches, with random gaps on both channels.", mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("vector3_fixed_point_alu_unit: match");
      else
         $display("vector3_fixed_point_alu_unit: mismatch");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run with the longest stalls.
   initial begin
      #400000;
      $display("Timeout with %0d response beats outstanding.", pending_results.size());
      $display("vector3_fixed_point_alu_unit: mismatch");
      $finish;
   end

endmodule
